>>> src/distance_constraint_relax_unit_macros.svh
// Assertion macros for the distance constraint relax unit checker.
`ifndef DISTANCE_CONSTRAINT_RELAX_UNIT_MACROS_SVH
`define DISTANCE_CONSTRAINT_RELAX_UNIT_MACROS_SVH

// Clocked property with reset disable.
`define DCR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds while reset is asserted.
`define DCR_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/dcr_pkg.sv
// ----------------------------------------------------------------------------
// dcr_pkg
// Shared types, sizes and helpers of the distance constraint relax unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dcr_pkg;

  localparam int unsigned SQRT_BITS  = 34;  // root of a 66-bit sum
  localparam int unsigned QUO_BITS   = 35;  // correction magnitude bits
  localparam int unsigned Q_DEPTH    = 4;
  localparam int unsigned Q_PTR_W    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
    logic [2:0]       neg;   // sign of each delta component
    logic [2:0][32:0] mag;   // magnitude of each delta component
    logic [30:0]      rest;
  } spring_t;

  typedef struct packed {
    spring_t     sp;
    logic [65:0] sum;        // squared length
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [31:0] sat32(input logic [35:0] v);
    logic [31:0] r;
    if (v[35] && (v[34:31] != 4'hF)) begin
      r = 32'h8000_0000;
    end else if (!v[35] && (v[34:31] != 4'h0)) begin
      r = 32'h7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/distance_constraint_relax_unit.sv
// Throughput: one spring per cycle while neither half stalls; the square root (34 stages) and the
// per-axis divider (35 stages) are fully pipelined.
// The front and back halves stall independently across a 4-entry queue.
// Reset (rst_ni low, asynchronous) empties the queue and all pipeline valids.
// ----------------------------------------------------------------------------
// distance_constraint_relax_unit
// Distance constraint relaxation for one spring per transaction, Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_constraint_relax_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] end_a_x_i,
  input  wire logic signed [31:0] end_a_y_i,
  input  wire logic signed [31:0] end_a_z_i,
  input  wire logic signed [31:0] end_b_x_i,
  input  wire logic signed [31:0] end_b_y_i,
  input  wire logic signed [31:0] end_b_z_i,
  input  wire logic        [30:0] rest_length_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      new_a_x_o,
  output logic signed [31:0]      new_a_y_o,
  output logic signed [31:0]      new_a_z_o,
  output logic signed [31:0]      new_b_x_o,
  output logic signed [31:0]      new_b_y_o,
  output logic signed [31:0]      new_b_z_o,
  output logic                    degenerate_o
);

  logic               push, pop;
  dcr_pkg::q_entry_t  push_data, pop_data;
  dcr_pkg::q_status_t q_status;

  dcr_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .end_a_x_i, .end_a_y_i, .end_a_z_i,
    .end_b_x_i, .end_b_y_i, .end_b_z_i, .rest_length_i,
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  dcr_queue u_queue (
    .clk_i, .rst_ni,
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  dcr_back u_back (
    .clk_i, .rst_ni,
    .q_status_i (q_status),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .out_valid_o, .out_stall_i,
    .new_a_x_o, .new_a_y_o, .new_a_z_o,
    .new_b_x_o, .new_b_y_o, .new_b_z_o, .degenerate_o
  );

endmodule

`default_nettype wire

>>> src/dcr_front.sv
// ----------------------------------------------------------------------------
// dcr_front
// Takes springs, forms deltas and the squared length, pushes to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dcr_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] end_a_x_i,
  input  wire logic signed [31:0] end_a_y_i,
  input  wire logic signed [31:0] end_a_z_i,
  input  wire logic signed [31:0] end_b_x_i,
  input  wire logic signed [31:0] end_b_y_i,
  input  wire logic signed [31:0] end_b_z_i,
  input  wire logic        [30:0] rest_length_i,
  input  wire dcr_pkg::q_status_t q_status_i,
  output logic                    push_o,
  output dcr_pkg::q_entry_t       push_data_o
);

  logic             en;
  logic             v1_q, v2_q;
  logic [2:0][31:0] a1_q, b1_q;
  logic [2:0][32:0] d1_q;
  logic [30:0]      rest1_q;
  logic [2:0][32:0] d_d;
  logic [2:0][31:0] a_in, b_in;
  dcr_pkg::spring_t sp2_q, sp2_d;
  logic [2:0][65:0] sq2_q, sq2_d;

  assign en         = !v2_q || !q_status_i.full;
  assign in_stall_o = !en;

  assign a_in = {end_a_z_i, end_a_y_i, end_a_x_i};
  assign b_in = {end_b_z_i, end_b_y_i, end_b_x_i};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_d[i] = {a_in[i][31], a_in[i]} - {b_in[i][31], b_in[i]};
    end
  end

  always_comb begin
    sp2_d.a    = a1_q;
    sp2_d.b    = b1_q;
    sp2_d.rest = rest1_q;
    for (int i = 0; i < 3; i++) begin
      sp2_d.neg[i] = d1_q[i][32];
      sp2_d.mag[i] = d1_q[i][32] ? (33'd0 - d1_q[i]) : d1_q[i];
      sq2_d[i]     = {33'd0, sp2_d.mag[i]} * {33'd0, sp2_d.mag[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q    <= a_in;
      b1_q    <= b_in;
      d1_q    <= d_d;
      rest1_q <= rest_length_i;
      sp2_q   <= sp2_d;
      sq2_q   <= sq2_d;
    end
  end

  assign push_o           = v2_q && !q_status_i.full;
  assign push_data_o.sp   = sp2_q;
  assign push_data_o.sum  = sq2_q[0] + sq2_q[1] + sq2_q[2];

endmodule

`default_nettype wire

>>> src/dcr_queue.sv
// ----------------------------------------------------------------------------
// dcr_queue
// Short register FIFO between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module dcr_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire dcr_pkg::q_entry_t  push_data_i,
  input  wire logic               pop_i,
  output dcr_pkg::q_entry_t       pop_data_o,
  output dcr_pkg::q_status_t      status_o
);

  dcr_pkg::q_entry_t                mem_q [dcr_pkg::Q_DEPTH];
  logic [dcr_pkg::Q_PTR_W-1:0]      wr_q, rd_q;
  logic [dcr_pkg::Q_PTR_W:0]        cnt_q;

  assign status_o.full  = (cnt_q == (dcr_pkg::Q_PTR_W+1)'(dcr_pkg::Q_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign pop_data_o     = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

>>> src/dcr_back.sv
// ----------------------------------------------------------------------------
// dcr_back
// Pipelined square root, scale, per-axis division and saturating update.
// ----------------------------------------------------------------------------
`default_nettype none

module dcr_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dcr_pkg::q_status_t q_status_i,
  input  wire dcr_pkg::q_entry_t  pop_data_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      new_a_x_o,
  output logic signed [31:0]      new_a_y_o,
  output logic signed [31:0]      new_a_z_o,
  output logic signed [31:0]      new_b_x_o,
  output logic signed [31:0]      new_b_y_o,
  output logic signed [31:0]      new_b_z_o,
  output logic                    degenerate_o
);

  localparam int unsigned SB = dcr_pkg::SQRT_BITS;
  localparam int unsigned QB = dcr_pkg::QUO_BITS;

  logic en;

  // square root stages
  logic                  sv_q    [SB+1];
  dcr_pkg::spring_t      ssp_q   [SB+1];
  logic [67:0]           srem_q  [SB+1];
  logic [SB-1:0]         sroot_q [SB+1];

  // division stages
  logic                  dv_q    [QB+1];
  dcr_pkg::spring_t      dsp_q   [QB+1];
  logic [QB-1:0]         dden_q  [QB+1];
  logic                  dnegd_q [QB+1];
  logic                  ddeg_q  [QB+1];
  logic [2:0][QB-1:0]    drem_q  [QB+1];
  logic [2:0][QB-1:0]    dquo_q  [QB+1];
  logic [2:0][66:0]      dprod_q [QB+1];

  logic                  out_valid_q;

  assign en          = !out_valid_q || !out_stall_i;
  assign pop_o       = en && !q_status_i.empty;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else if (en) begin
      sv_q[0] <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ssp_q[0]   <= pop_data_i.sp;
      srem_q[0]  <= {2'b00, pop_data_i.sum};
      sroot_q[0] <= '0;
    end
  end

  // one root bit per stage, most significant first
  for (genvar j = 0; j < SB; j++) begin : g_sqrt
    localparam int unsigned B = SB - 1 - j;
    logic [67:0] trial;
    logic        ge;

    assign trial = ({{(68-SB){1'b0}}, sroot_q[j]} << (B + 1)) + (68'd1 << (2 * B));
    assign ge    = (trial <= srem_q[j]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[j+1] <= 1'b0;
      end else if (en) begin
        sv_q[j+1] <= sv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        ssp_q[j+1]   <= ssp_q[j];
        srem_q[j+1]  <= ge ? (srem_q[j] - trial) : srem_q[j];
        sroot_q[j+1] <= sroot_q[j] | (ge ? (SB'(1) << B) : '0);
      end
    end
  end

  // scale stage: rest - dist, then |delta_i| * |rest - dist|
  logic [SB:0]       diff;
  logic [SB-1:0]     dmag;
  logic [2:0][66:0]  prod;

  assign diff = {{(SB-30){1'b0}}, ssp_q[SB].rest} - {1'b0, sroot_q[SB]};
  assign dmag = diff[SB] ? SB'(({(SB+1){1'b0}}) - diff) : diff[SB-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = {34'd0, ssp_q[SB].mag[i]} * {33'd0, dmag};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= sv_q[SB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dsp_q[0]   <= ssp_q[SB];
      dden_q[0]  <= {sroot_q[SB], 1'b0};
      dnegd_q[0] <= diff[SB];
      ddeg_q[0]  <= (sroot_q[SB] == '0);
      dprod_q[0] <= prod;
      for (int i = 0; i < 3; i++) begin
        drem_q[0][i] <= {3'b000, prod[i][66:QB]};
        dquo_q[0][i] <= '0;
      end
    end
  end

  // restoring division, one quotient bit per stage for all three axes
  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int unsigned I = QB - 1 - k;
    logic [2:0][QB:0]   sh;
    logic [2:0]         ge;
    logic [2:0][QB-1:0] rem_n;
    logic [2:0][QB-1:0] quo_n;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        sh[i]    = {drem_q[k][i], dprod_q[k][i][I]};
        ge[i]    = (sh[i] >= {1'b0, dden_q[k]});
        rem_n[i] = ge[i] ? QB'(sh[i] - {1'b0, dden_q[k]}) : sh[i][QB-1:0];
        quo_n[i] = dquo_q[k][i] | (ge[i] ? (QB'(1) << I) : '0);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else if (en) begin
        dv_q[k+1] <= dv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dsp_q[k+1]   <= dsp_q[k];
        dden_q[k+1]  <= dden_q[k];
        dnegd_q[k+1] <= dnegd_q[k];
        ddeg_q[k+1]  <= ddeg_q[k];
        dprod_q[k+1] <= dprod_q[k];
        drem_q[k+1]  <= rem_n;
        dquo_q[k+1]  <= quo_n;
      end
    end
  end

  // apply the correction, pass through when the spring has zero length
  logic [2:0][35:0] corr;
  logic [2:0][31:0] na_d, nb_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      corr[i] = (dsp_q[QB].neg[i] ^ dnegd_q[QB]) ? (36'd0 - {1'b0, dquo_q[QB][i]})
                                                 : {1'b0, dquo_q[QB][i]};
      if (ddeg_q[QB]) begin
        na_d[i] = dsp_q[QB].a[i];
        nb_d[i] = dsp_q[QB].b[i];
      end else begin
        na_d[i] = dcr_pkg::sat32({{4{dsp_q[QB].a[i][31]}}, dsp_q[QB].a[i]} + corr[i]);
        nb_d[i] = dcr_pkg::sat32({{4{dsp_q[QB].b[i][31]}}, dsp_q[QB].b[i]} - corr[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      new_a_x_o    <= na_d[0];
      new_a_y_o    <= na_d[1];
      new_a_z_o    <= na_d[2];
      new_b_x_o    <= nb_d[0];
      new_b_y_o    <= nb_d[1];
      new_b_z_o    <= nb_d[2];
      degenerate_o <= ddeg_q[QB];
    end
  end

endmodule

`default_nettype wire

>>> src/dcr_checker.sv
// ----------------------------------------------------------------------------
// dcr_checker
// Port-level checks of the distance constraint relax unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "distance_constraint_relax_unit_macros.svh"

module dcr_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [31:0] new_a_x_o,
  input wire logic signed [31:0] new_b_z_o,
  input wire logic               degenerate_o
);

  `DCR_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")
  `DCR_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(new_a_x_o) && $stable(new_b_z_o) && $stable(degenerate_o), "stalled result changed")
  `DCR_ASSERT_RST(a_rst_quiet, clk_i, !rst_ni |=> !out_valid_o, "result shown out of reset")
  `DCR_ASSERT(a_no_early, clk_i, rst_ni, $rose(rst_ni) |-> !out_valid_o, "result right after reset")
  `DCR_ASSERT(a_in_hold, clk_i, rst_ni, in_valid_i && in_stall_o |=> in_valid_i, "input withdrawn while stalled")

endmodule

bind distance_constraint_relax_unit dcr_checker u_dcr_checker (.*);

`default_nettype wire
